@@ src/rdit_pkg.sv @@
package rdit_pkg;

   localparam int TIME_W = 32;
   localparam int CSR_IDX_W = 2;
   localparam int MAX_FIRES_DEFAULT = 16;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 64;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DELAY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FOREVER = 2'd3;

   localparam logic [TIME_W-1:0] TIME_ALL_ONES = '1;

   typedef logic [TIME_W-1:0] time_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

@@ src/repeating_delay_interval_timer.sv @@
// Periodic timer with an initial delay and a repeat count.
// req channel: one tick per transfer, carrying the time passed (Q16.16 s).
// rsp channel: one transfer per fire; tdata holds fire amount and fire number,
// tuser flags the fire that used up the repeat limit, tlast marks the final
// fire of a tick. The csr port writes interval, delay, repeat limit and the
// run-forever flag; every write restarts the timer. A write is to be taken
// only while idle: the user is bound to this, the block does not enforce it.
// The first tick after reset or after a write only arms the timer; ticks
// after the timer has stopped are dropped without result. Ticks pass through
// a two-entry queue to a sequencer that owns the timer state. It dequeues
// and accumulates a tick in its idle state, checks the delay, and then issues
// the fires from its delay-output and loop states, the delay fire included.
// It takes a new tick from the queue only once it is back in its idle state.
// The rsp outputs are registered. Up to MAX_FIRES_PER_TICK fires come from
// one tick. A stalled rsp side holds the sequencer on the current fire; the
// queue still takes ticks until it is full. Reset clears the timer, sets the
// registers to zero with run-forever on, and empties the queue.
module repeating_delay_interval_timer
   import rdit_pkg::*;
#(
   parameter int MAX_FIRES_PER_TICK = MAX_FIRES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [31:0] tick_amount
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [31:0] fire_amount, [63:32] fire_number
   output logic                   rsp_tuser,   // [0] finished
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [TIME_W-1:0]      csr_data
);

   queue_stat_type q_stat;
   logic           push;
   time_type       push_data;
   logic           pop;
   time_type       pop_data;

   rdit_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_stat     (q_stat),
      .push       (push),
      .push_data  (push_data)
   );

   rdit_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (q_stat)
   );

   rdit_back #(
      .MAX_FIRES_PER_TICK (MAX_FIRES_PER_TICK)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_stat     (q_stat),
      .q_data     (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ src/rdit_fifo.sv @@
module rdit_fifo
   import rdit_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  time_type       push_data,
   input  logic           pop,
   output time_type       pop_data,
   output queue_stat_type stat
);

   time_type               mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]    count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign stat.full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_data   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ src/rdit_front.sv @@
module rdit_front
   import rdit_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  queue_stat_type         q_stat,
   output logic                   push,
   output time_type               push_data
);

   logic armed_ff, armed_in;
   logic accept;

   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;

   // the arming transfer only arms; later ticks go on to the queue
   assign push      = accept && armed_ff;
   assign push_data = req_tdata[TIME_W-1:0];

   always_comb begin
      armed_in = armed_ff;
      if (csr_we) begin
         armed_in = 1'b0;
      end else if (accept) begin
         armed_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
      end else begin
         armed_ff <= armed_in;
      end
   end

endmodule

@@ src/rdit_back.sv @@
module rdit_back
   import rdit_pkg::*;
#(
   parameter int MAX_FIRES_PER_TICK = MAX_FIRES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [TIME_W-1:0]      csr_data,
   input  queue_stat_type         q_stat,
   input  time_type               q_data,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser,
   output logic                   rsp_tlast
);

   localparam int CNT_W = $clog2(MAX_FIRES_PER_TICK + 1);
   localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_FIRES_PER_TICK);

   localparam logic [1:0] ST_IDLE      = 2'd0;
   localparam logic [1:0] ST_DELAY     = 2'd1;
   localparam logic [1:0] ST_DELAY_OUT = 2'd2;
   localparam logic [1:0] ST_LOOP      = 2'd3;

   logic [1:0]       state_ff, state_in;
   time_type         interval_ff, interval_in;
   time_type         delay_ff, delay_in;
   time_type         limit_ff, limit_in;
   logic             forever_ff, forever_in;
   time_type         elapsed_ff, elapsed_in;
   time_type         total_ff, total_in;
   logic             pending_ff, pending_in;
   logic             stopped_ff, stopped_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             hold_fin_ff, hold_fin_in;

   logic             rsp_valid_ff, rsp_valid_in;
   time_type         rsp_amount_ff, rsp_amount_in;
   time_type         rsp_number_ff, rsp_number_in;
   logic             rsp_fin_ff, rsp_fin_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             slot_free;
   logic             emit;
   time_type         emit_amount;
   time_type         emit_number;
   logic             emit_fin;
   logic             emit_last;
   time_type         total_inc;
   logic             exhaust_next;
   logic             iv_zero;
   logic             ge_iv;
   logic             ge_2iv;
   logic             ge_delay;
   logic             fire_ok;
   logic [TIME_W:0]  sum;
   time_type         sat_sum;
   time_type         loop_amount;

   assign slot_free    = !rsp_valid_ff || rsp_tready;
   assign total_inc    = (total_ff == TIME_ALL_ONES) ? total_ff : total_ff + 1'b1;
   assign exhaust_next = !forever_ff && (total_inc > limit_ff);
   assign iv_zero      = (interval_ff == '0);
   assign ge_iv        = (elapsed_ff >= interval_ff);
   // elapsed minus interval still covers interval
   assign ge_2iv       = ({1'b0, elapsed_ff} >= {interval_ff, 1'b0});
   assign ge_delay     = (elapsed_ff >= delay_ff);
   assign sum          = {1'b0, elapsed_ff} + {1'b0, q_data};
   assign sat_sum      = sum[TIME_W] ? TIME_ALL_ONES : sum[TIME_W-1:0];
   assign loop_amount  = iv_zero ? elapsed_ff : interval_ff;
   assign fire_ok      = (cnt_ff < CAP) && (iv_zero || ge_iv);

   always_comb begin
      state_in    = state_ff;
      interval_in = interval_ff;
      delay_in    = delay_ff;
      limit_in    = limit_ff;
      forever_in  = forever_ff;
      elapsed_in  = elapsed_ff;
      total_in    = total_ff;
      pending_in  = pending_ff;
      stopped_in  = stopped_ff;
      cnt_in      = cnt_ff;
      hold_fin_in = hold_fin_ff;
      pop         = 1'b0;
      emit        = 1'b0;
      emit_amount = loop_amount;
      emit_number = total_inc;
      emit_fin    = exhaust_next;
      emit_last   = 1'b0;

      if (csr_we) begin
         case (csr_index)
            REG_INTERVAL: interval_in = csr_data;
            REG_DELAY:    delay_in    = csr_data;
            REG_REPEAT:   limit_in    = csr_data;
            REG_FOREVER:  forever_in  = csr_data[0];
            default:      interval_in = interval_ff;
         endcase
         // restart the timer
         state_in   = ST_IDLE;
         elapsed_in = '0;
         total_in   = '0;
         stopped_in = 1'b0;
         pending_in = (csr_index == REG_DELAY) ? (csr_data != '0) : (delay_ff != '0);
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (!q_stat.empty) begin
                  pop = 1'b1;
                  // drop ticks while stopped
                  if (!stopped_ff) begin
                     elapsed_in = sat_sum;
                     cnt_in     = '0;
                     state_in   = ST_DELAY;
                  end
               end
            end
            ST_DELAY: begin
               if (!pending_ff) begin
                  state_in = ST_LOOP;
               end else if (!ge_delay) begin
                  state_in = ST_IDLE;
               end else begin
                  elapsed_in  = elapsed_ff - delay_ff;
                  pending_in  = 1'b0;
                  total_in    = total_inc;
                  hold_fin_in = exhaust_next;
                  stopped_in  = exhaust_next;
                  cnt_in      = CNT_W'(1);
                  state_in    = ST_DELAY_OUT;
               end
            end
            ST_DELAY_OUT: begin
               if (slot_free) begin
                  emit        = 1'b1;
                  emit_amount = delay_ff;
                  emit_number = total_ff;
                  emit_fin    = hold_fin_ff;
                  emit_last   = hold_fin_ff || (cnt_ff == CAP) || (!iv_zero && !ge_iv);
                  state_in    = emit_last ? ST_IDLE : ST_LOOP;
               end
            end
            ST_LOOP: begin
               if (!fire_ok) begin
                  state_in = ST_IDLE;
               end else if (slot_free) begin
                  emit       = 1'b1;
                  emit_last  = exhaust_next || iv_zero
                               || (CNT_W'(cnt_ff + 1'b1) == CAP) || !ge_2iv;
                  total_in   = total_inc;
                  stopped_in = exhaust_next;
                  elapsed_in = elapsed_ff - loop_amount;
                  cnt_in     = CNT_W'(cnt_ff + 1'b1);
                  state_in   = emit_last ? ST_IDLE : ST_LOOP;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_amount_in = rsp_amount_ff;
      rsp_number_in = rsp_number_ff;
      rsp_fin_in    = rsp_fin_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_amount_in = emit_amount;
         rsp_number_in = emit_number;
         rsp_fin_in    = emit_fin;
         rsp_last_in   = emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         interval_ff  <= '0;
         delay_ff     <= '0;
         limit_ff     <= '0;
         forever_ff   <= 1'b1;
         elapsed_ff   <= '0;
         total_ff     <= '0;
         pending_ff   <= 1'b0;
         stopped_ff   <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         interval_ff  <= interval_in;
         delay_ff     <= delay_in;
         limit_ff     <= limit_in;
         forever_ff   <= forever_in;
         elapsed_ff   <= elapsed_in;
         total_ff     <= total_in;
         pending_ff   <= pending_in;
         stopped_ff   <= stopped_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_fin_ff   <= hold_fin_in;
      rsp_amount_ff <= rsp_amount_in;
      rsp_number_ff <= rsp_number_in;
      rsp_fin_ff    <= rsp_fin_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_number_ff, rsp_amount_ff};
   assign rsp_tuser  = rsp_fin_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ tb/sv/tb_repeating_delay_interval_timer.sv @@
module tb_repeating_delay_interval_timer;
   import rdit_pkg::*;

   localparam int FIRE_CAP = MAX_FIRES_DEFAULT;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef struct packed {
      time_type amount;
      time_type number;
      logic     finished;
      logic     last_of_tick;
   } fire_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // [31:0] tick_amount
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // [31:0] fire_amount, [63:32] fire_number
   logic                   rsp_tuser;        // [0] finished
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = REG_INTERVAL;
   logic [TIME_W-1:0]      csr_data = '0;

   // timer registers as written
   time_type cfg_interval = '0;
   time_type cfg_delay = '0;
   time_type cfg_repeat = '0;
   logic     cfg_forever = 1'b1;

   // predicted timer state
   logic     tmr_armed = 1'b0;
   logic     tmr_delay_pending = 1'b0;
   time_type tmr_elapsed = '0;
   time_type tmr_count = '0;
   logic     tmr_stopped = 1'b0;

   fire_type fires_due[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_cycles = 0;
   int error_count = 0;
   int ticks_sent = 0;
   int fires_checked = 0;
   int reg_writes = 0;
   int input_stalls = 0;
   int quiet_cycles = 0;

   repeating_delay_interval_timer #(
      .MAX_FIRES_PER_TICK(FIRE_CAP)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void restart_timer();
      tmr_armed = 1'b0;
      tmr_delay_pending = (cfg_delay != 0);
      tmr_elapsed = '0;
      tmr_count = '0;
      tmr_stopped = 1'b0;
   endfunction

   function automatic void record_fire(time_type amt);
      fire_type f;
      if (tmr_count != TIME_ALL_ONES) tmr_count++;
      f.amount = amt;
      f.number = tmr_count;
      f.finished = !cfg_forever && (tmr_count > cfg_repeat);
      f.last_of_tick = 1'b0;
      if (f.finished) tmr_stopped = 1'b1;
      fires_due.push_back(f);
   endfunction

   function automatic void predict_fires(time_type amt);
      int base;
      time_type step;
      base = fires_due.size();
      if (tmr_stopped) return;
      if (!tmr_armed) begin
         tmr_armed = 1'b1;
         tmr_elapsed = '0;
         tmr_count = '0;
         return;
      end
      if (TIME_ALL_ONES - tmr_elapsed < amt) tmr_elapsed = TIME_ALL_ONES;
      else tmr_elapsed += amt;
      if (tmr_delay_pending) begin
         if (tmr_elapsed < cfg_delay) return;
         record_fire(cfg_delay);
         tmr_elapsed -= cfg_delay;
         tmr_delay_pending = 1'b0;
      end
      // a zero interval takes the whole remainder, zero included
      step = (cfg_interval != 0) ? cfg_interval : tmr_elapsed;
      while (!tmr_stopped && fires_due.size() - base < FIRE_CAP && tmr_elapsed >= step) begin
         record_fire(step);
         tmr_elapsed -= step;
         if (tmr_elapsed == 0) break;
      end
      if (fires_due.size() > base) fires_due[fires_due.size() - 1].last_of_tick = 1'b1;
   endfunction

   // ---------------------------------------------------------------- drivers

   // leaves tvalid high so that the next tick can follow without a gap
   task automatic send_tick(time_type amt);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = amt;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_fires(amt);
      ticks_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (fires_due.size() != 0) @(posedge clock);
      // ticks without a fire may still be in the block
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, time_type value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_data = value;
      case (idx)
         REG_INTERVAL: cfg_interval = value;
         REG_DELAY:    cfg_delay = value;
         REG_REPEAT:   cfg_repeat = value;
         REG_FOREVER:  cfg_forever = value[0];
         default: ;
      endcase
      restart_timer();
      reg_writes++;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic configure(time_type interval, time_type delay, time_type repeats, logic forever_on);
      drain();
      write_reg(REG_INTERVAL, interval);
      write_reg(REG_DELAY, delay);
      write_reg(REG_REPEAT, repeats);
      write_reg(REG_FOREVER, {31'b0, forever_on});
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready = 1'b0;
         hold_cycles--;
      end else begin
         rsp_tready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin : check_fires
      fire_type want;
      if (!reset && req_tvalid && !req_tready) input_stalls++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         fires_checked++;
         if (fires_due.size() == 0) begin
            report_mismatch("fire with nothing outstanding", rsp_tdata[31:0], '0);
         end else begin
            want = fires_due.pop_front();
            if (rsp_tdata[31:0] !== want.amount)
               report_mismatch("fire_amount", rsp_tdata[31:0], want.amount);
            if (rsp_tdata[63:32] !== want.number)
               report_mismatch("fire_number", rsp_tdata[63:32], want.number);
            if (rsp_tuser !== want.finished)
               report_mismatch("finished", {31'b0, rsp_tuser}, {31'b0, want.finished});
            if (rsp_tlast !== want.last_of_tick)
               report_mismatch("last_of_tick", {31'b0, rsp_tlast}, {31'b0, want.last_of_tick});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d fires outstanding",
                     WATCHDOG_LIMIT, fires_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_power_on_defaults();
      // zero interval, no delay, run forever: every tick after the arming one fires its own amount
      send_tick(32'h0000_1234);
      send_tick(32'd5);
      send_tick('0);
      send_tick(TIME_ALL_ONES);
   endtask

   task automatic test_delay_then_interval();
      configure(32'h0001_0000, 32'h0003_0000, 32'd3, 1'b0);
      send_tick(32'hDEAD_BEEF);
      send_tick(32'h0001_8000);
      send_tick(32'h0001_8000);
      send_tick(32'h0002_5000);
      send_tick(32'h0001_0000);
      send_tick(32'd5);
   endtask

   task automatic test_fire_cap_and_saturation();
      configure(32'd1, '0, TIME_ALL_ONES, 1'b0);
      send_tick('0);
      send_tick(32'd100);
      send_tick(TIME_ALL_ONES);
      send_tick(TIME_ALL_ONES);
   endtask

   task automatic test_delay_with_zero_interval();
      // delay fire alone uses up a zero repeat limit; later ticks are dropped
      configure('0, 32'd7, '0, 1'b0);
      send_tick(32'd3);
      send_tick(32'd10);
      send_tick(32'd3);
      // full delay, then a zero-interval fire of nothing in the same tick
      configure('0, TIME_ALL_ONES, 32'd5, 1'b0);
      send_tick('0);
      send_tick(TIME_ALL_ONES);
      send_tick(32'h0000_8000);
   endtask

   task automatic test_backpressure();
      int saved_idle;
      saved_idle = send_idle_pct;
      configure(32'd1, '0, '0, 1'b1);
      send_idle_pct = 0;
      send_tick('0);
      hold_cycles = HOLD_OFF_CYCLES;
      for (int k = 0; k < 8; k++) send_tick(32'd40);
      send_idle_pct = saved_idle;
   endtask

   task automatic test_random_ticks(int want, int send_idle, int rsp_stall);
      int live;
      time_type iv;
      time_type dl;
      time_type rp;
      time_type span;
      time_type amt;
      send_idle_pct = send_idle;
      rsp_stall_pct = rsp_stall;
      live = 0;
      while (live < want) begin
         case ($urandom_range(5))
            0:       iv = '0;
            1:       iv = $urandom;
            2:       iv = TIME_ALL_ONES;
            default: iv = $urandom_range(1, 32'h0002_0000);
         endcase
         case ($urandom_range(3))
            0, 1:    dl = '0;
            2:       dl = $urandom_range(1, 32'h0004_0000);
            default: dl = $urandom;
         endcase
         case ($urandom_range(2))
            0:       rp = '0;
            1:       rp = $urandom_range(1, 20);
            default: rp = TIME_ALL_ONES;
         endcase
         configure(iv, dl, rp, 1'($urandom_range(1)));
         span = (iv > dl) ? iv : dl;
         if (span == 0) span = 32'h0001_0000;
         span = (span > 32'h7FFF_FFFF) ? TIME_ALL_ONES : span * 3;
         // stop early once the timer has stopped and restart with new settings
         for (int k = 0; k < 12 && live < want && !tmr_stopped; k++) begin
            case ($urandom_range(9))
               0:       amt = '0;
               1:       amt = TIME_ALL_ONES;
               2, 3:    amt = $urandom;
               default: amt = $urandom_range(0, span);
            endcase
            send_tick(amt);
            live++;
         end
      end
   endtask

   initial begin
      restart_timer();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 15;
      rsp_stall_pct = 59;
      test_power_on_defaults();
      test_delay_then_interval();
      test_fire_cap_and_saturation();
      test_delay_with_zero_interval();
      test_backpressure();
      test_random_ticks(25, 15, 59);
      test_random_ticks(25, 59, 15);
      test_random_ticks(25, 0, 0);
      drain();

      $display("Covered %0d ticks and %0d fires over %0d register writes",
               ticks_sent, fires_checked, reg_writes);
      $display("Tick input held off by a full block for %0d cycles", input_stalls);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
